### design/pwrcd_pkg.sv
package pwrcd_pkg;

   // Code length and derived window size
   localparam int CODE_BITS = 12;
   localparam int WIN_LEN   = 2 * CODE_BITS;

   // Field widths
   localparam int DUR_W      = 24;
   localparam int REG_W      = 23;
   localparam int OUT_CODE_W = 12;
   localparam int SERIAL_W   = 10;
   localparam int BUTTON_W   = 2;
   localparam int CSR_IDX_W  = 2;

   // Register reset values, microseconds
   localparam logic [REG_W-1:0] SHORT_MIN_RST = REG_W'(280);
   localparam logic [REG_W-1:0] SHORT_MAX_RST = REG_W'(1120);
   localparam logic [REG_W-1:0] LONG_MIN_RST  = REG_W'(560);
   localparam logic [REG_W-1:0] LONG_MAX_RST  = REG_W'(2240);

   // Queue between classifier and matcher (depth is a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_SHORT_MIN = 2'd0,
      CFG_SHORT_MAX = 2'd1,
      CFG_LONG_MIN  = 2'd2,
      CFG_LONG_MAX  = 2'd3
   } cfg_index_type;

   typedef struct packed {
      logic signed [DUR_W-1:0] duration;
      logic                    frame_last;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [OUT_CODE_W-1:0] code;
      logic [SERIAL_W-1:0]   serial;
      logic [BUTTON_W-1:0]   button;
   } rsp_type;

   // Duration class: mark flag plus short / long hits
   typedef struct packed {
      logic mark;
      logic short_hit;
      logic long_hit;
   } class_type;

   typedef struct packed {
      class_type cls;
      logic      last;
   } qent_type;

endpackage

### design/pwrcd_front.sv
module pwrcd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [pwrcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pwrcd_pkg::REG_W-1:0]     csr_wdata,
   input  pwrcd_pkg::req_type              req_data,
   output pwrcd_pkg::qent_type             ent
);

   logic [pwrcd_pkg::REG_W-1:0] short_min_ff, short_max_ff, long_min_ff, long_max_ff;
   logic [pwrcd_pkg::DUR_W-1:0] dur_u;
   logic [pwrcd_pkg::DUR_W-1:0] mag;
   logic                        neg;
   logic                        is_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_min_ff <= pwrcd_pkg::SHORT_MIN_RST;
         short_max_ff <= pwrcd_pkg::SHORT_MAX_RST;
         long_min_ff  <= pwrcd_pkg::LONG_MIN_RST;
         long_max_ff  <= pwrcd_pkg::LONG_MAX_RST;
      end else if (csr_we) begin
         unique case (pwrcd_pkg::cfg_index_type'(csr_index))
            pwrcd_pkg::CFG_SHORT_MIN: short_min_ff <= csr_wdata;
            pwrcd_pkg::CFG_SHORT_MAX: short_max_ff <= csr_wdata;
            pwrcd_pkg::CFG_LONG_MIN:  long_min_ff  <= csr_wdata;
            pwrcd_pkg::CFG_LONG_MAX:  long_max_ff  <= csr_wdata;
         endcase
      end
   end

   // Magnitude is exact: the most negative value gives 2^23, above every bound
   always_comb begin
      dur_u   = pwrcd_pkg::DUR_W'(req_data.duration);
      neg     = dur_u[pwrcd_pkg::DUR_W-1];
      is_zero = (dur_u == '0);
      mag     = neg ? pwrcd_pkg::DUR_W'(-dur_u) : dur_u;

      ent.last = req_data.frame_last;
      if (is_zero) begin
         ent.cls = '0;
      end else begin
         ent.cls.mark      = !neg;
         ent.cls.short_hit = (mag >= pwrcd_pkg::DUR_W'(short_min_ff)) &&
                             (mag <= pwrcd_pkg::DUR_W'(short_max_ff));
         ent.cls.long_hit  = (mag >= pwrcd_pkg::DUR_W'(long_min_ff)) &&
                             (mag <= pwrcd_pkg::DUR_W'(long_max_ff));
      end
   end

endmodule

### design/pwrcd_queue.sv
module pwrcd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pwrcd_pkg::qent_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output pwrcd_pkg::qent_type head_data
);

   pwrcd_pkg::qent_type                 slot_ff [pwrcd_pkg::QUEUE_DEPTH];
   logic [pwrcd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pwrcd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pwrcd_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == pwrcd_pkg::QUEUE_CNT_W'(pwrcd_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? pwrcd_pkg::QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? pwrcd_pkg::QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = pwrcd_pkg::QUEUE_CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = pwrcd_pkg::QUEUE_CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/pwrcd_back.sv
module pwrcd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  pwrcd_pkg::qent_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pwrcd_pkg::rsp_type  rsp_data
);

   pwrcd_pkg::class_type              win_ff [pwrcd_pkg::WIN_LEN];
   pwrcd_pkg::class_type              win_in [pwrcd_pkg::WIN_LEN];
   pwrcd_pkg::class_type              win_nx [pwrcd_pkg::WIN_LEN];
   logic                              reported_ff, reported_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   pwrcd_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic [pwrcd_pkg::CODE_BITS-1:0]   pair_ok;
   logic [pwrcd_pkg::CODE_BITS-1:0]   code_full;
   logic [pwrcd_pkg::OUT_CODE_W-1:0]  code_out;
   logic                              all_ok;
   logic                              emit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Take the next class whenever the output slot is free or being drained
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   // Window after this shift, oldest first
   always_comb begin
      for (int i = 0; i < pwrcd_pkg::WIN_LEN - 1; i++) begin
         win_nx[i] = win_ff[i+1];
      end
      win_nx[pwrcd_pkg::WIN_LEN-1] = head_data.cls;
   end

   // Pairs checked independently; bit 0 rule wins on overlap
   always_comb begin
      for (int i = 0; i < pwrcd_pkg::CODE_BITS; i++) begin
         pair_ok[i] = win_nx[2*i].mark && !win_nx[2*i+1].mark &&
                      ((win_nx[2*i].short_hit && win_nx[2*i+1].long_hit) ||
                       (win_nx[2*i].long_hit && win_nx[2*i+1].short_hit));
         code_full[pwrcd_pkg::CODE_BITS-1-i] =
            !(win_nx[2*i].short_hit && win_nx[2*i+1].long_hit);
      end
      all_ok   = &pair_ok;
      code_out = pwrcd_pkg::OUT_CODE_W'(code_full);
      emit     = !reported_ff && (all_ok || head_data.last);
   end

   always_comb begin
      win_in       = win_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         if (head_data.last) begin
            for (int i = 0; i < pwrcd_pkg::WIN_LEN; i++) begin
               win_in[i] = '0;
            end
            reported_in = 1'b0;
         end else begin
            win_in      = win_nx;
            reported_in = reported_ff || all_ok;
         end
         if (emit) begin
            rsp_valid_in       = 1'b1;
            rsp_data_in.found  = all_ok;
            rsp_data_in.code   = all_ok ? code_out : '0;
            rsp_data_in.serial = all_ok ?
               code_out[pwrcd_pkg::OUT_CODE_W-1:pwrcd_pkg::BUTTON_W] : '0;
            rsp_data_in.button = all_ok ? code_out[pwrcd_pkg::BUTTON_W-1:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pwrcd_pkg::WIN_LEN; i++) begin
            win_ff[i] <= '0;
         end
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### design/pulse_width_remote_code_decoder_core.sv
// Path: a duration transferred on req yields its result, if any, on rsp once
//   classified into the queue and then matched into the output register.
// Throughput: one duration per cycle unless rsp stalls, set by the window
//   shift and pair check in the back end; zero or one result per duration.
// Reset (synchronous, active high): bounds to 280/1120/560/2240 us, queue,
//   window and reported flag cleared, no result pending.
module pulse_width_remote_code_decoder_core (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pwrcd_pkg::req_type              req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pwrcd_pkg::rsp_type              rsp_data,
   // register writes
   input  logic                            csr_we,
   input  logic [pwrcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pwrcd_pkg::REG_W-1:0]     csr_wdata
);

   pwrcd_pkg::qent_type front_ent;
   pwrcd_pkg::qent_type head_data;
   logic                q_full;
   logic                head_valid;
   logic                pop;
   logic                push;

   // A transfer on req pushes straight into the queue
   assign push      = req_valid && !q_full;
   assign req_stall = q_full;

   // Front end: bound registers and duration classification
   pwrcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .ent       (front_ent)
   );

   // Short queue decouples req stall from rsp stall
   pwrcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (front_ent),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Back end: sliding class window, pair match, once-per-frame report
   pwrcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
